[rtl/core/soc_cc_pkg.sv]
// Shared types, widths and constants of the coulomb-counting state-of-charge block.
package soc_cc_pkg;

	// field widths
	localparam int VOLT_W   = 17;
	localparam int CUR_W    = 21;
	localparam int TIME_W   = 32;
	localparam int SOC_W    = 32;
	localparam int STAT_W   = 2;
	localparam int CAP_W    = 24;
	localparam int CFG_W    = 32;
	localparam int IDX_W    = 3;

	// serial arithmetic widths
	localparam int MUL_A_W  = CUR_W;               // |current|, up to 2^20
	localparam int MUL_B_W  = TIME_W;              // |elapsed|, up to 2^31
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int DIVD_W   = 57;                  // holds |p|*5 and used*100
	localparam int DIVS_W   = CAP_W;
	localparam int SUM_W    = DIVD_W + 2;

	typedef logic [VOLT_W-1:0]         volt_t;
	typedef logic signed [CUR_W-1:0]   cur_t;
	typedef logic [TIME_W-1:0]         time_t;
	typedef logic signed [SOC_W-1:0]   soc_t;
	typedef logic [STAT_W-1:0]         stat_t;
	typedef logic [IDX_W-1:0]          reg_idx_t;
	typedef logic [CFG_W-1:0]          cfg_data_t;
	typedef logic [MUL_A_W-1:0]        mul_a_t;
	typedef logic [MUL_B_W-1:0]        mul_b_t;
	typedef logic [PROD_W-1:0]         prod_t;
	typedef logic [DIVD_W-1:0]         divd_t;
	typedef logic [DIVS_W-1:0]         divs_t;

	// register indexes
	localparam reg_idx_t REG_FULL_THR  = 3'd0;
	localparam reg_idx_t REG_EMPTY_THR = 3'd1;
	localparam reg_idx_t REG_CAPACITY  = 3'd2;
	localparam reg_idx_t REG_INIT_SOC  = 3'd3;

	// result status codes
	localparam stat_t ST_INTEGRATED = 2'd0;
	localparam stat_t ST_FULL       = 2'd1;
	localparam stat_t ST_EMPTY      = 2'd2;
	localparam stat_t ST_SATURATED  = 2'd3;

	localparam soc_t SOC_FULL  = 32'sd99999999;
	localparam soc_t SOC_EMPTY = 32'sd1000000;
	localparam soc_t SOC_MAX   = 32'sh7FFF_FFFF;
	localparam soc_t SOC_MIN   = 32'sh8000_0000;

	// ms*1000/3600 reduces to *5/18
	localparam divs_t DIV_HOUR = 24'd18;

endpackage

[rtl/core/soc_cc_ifs.sv]
// Request channels: measurement in, state-of-charge result out.
interface soc_cc_meas_if;
	import soc_cc_pkg::*;
	logic   valid;
	logic   ready;
	volt_t  voltage_mv;
	cur_t   current_ma;
	time_t  timestamp_ms;

	modport source (output valid, voltage_mv, current_ma, timestamp_ms, input ready);
	modport sink   (input valid, voltage_mv, current_ma, timestamp_ms, output ready);
endinterface

interface soc_cc_result_if;
	import soc_cc_pkg::*;
	logic   valid;
	logic   ready;
	soc_t   soc_value;
	stat_t  soc_status;

	modport source (output valid, soc_value, soc_status, input ready);
	modport sink   (input valid, soc_value, soc_status, output ready);
endinterface

[rtl/core/soc_cc_mul.sv]
// Bit-serial shift-add multiplier for the current and elapsed-time magnitudes.
module soc_cc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  soc_cc_pkg::mul_a_t  a,
	input  soc_cc_pkg::mul_b_t  b,
	output logic                done,
	output soc_cc_pkg::prod_t   product
);
	import soc_cc_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	mul_a_t             a_q;
	prod_t              prod_q;
	logic [MUL_A_W:0]   part_sum;

	// one multiplier bit a cycle, consumed from the low end
	assign part_sum = {1'b0, prod_q[PROD_W-1 -: MUL_A_W]}
		+ (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MUL_B_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {part_sum, prod_q[MUL_B_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = prod_q;

endmodule

[rtl/core/soc_cc_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle, shared by both divisions.
module soc_cc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  soc_cc_pkg::divd_t   dividend,
	input  soc_cc_pkg::divs_t   divisor,
	output logic                done,
	output soc_cc_pkg::divd_t   quotient
);
	import soc_cc_pkg::*;

	localparam int CNT_W = $clog2(DIVD_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	divd_t              dq_q;
	divs_t              rem_q;
	divs_t              dvs_q;
	logic [DIVS_W:0]    shifted;
	logic [DIVS_W:0]    diff;
	logic               ge;

	assign shifted = {rem_q, dq_q[DIVD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DIVD_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// dividend shifts out of the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIVD_W-2:0], ge};
			rem_q <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

[rtl/core/battery_soc_coulomb_counter.sv]
// Coulomb-counting state-of-charge estimator, top level.
// Sequence: a forced full or empty sample goes from idle to the done state, then into the output
//   register; an integrated sample first passes the multiply, the divide by 18 and the divide by capacity.
// Throughput: one request in flight; the next is taken once the sequencer is back in idle,
//   so the bit-serial multiplier and divider bound the rate of integrated samples.
// Reset (arst_n, asynchronous): thresholds 0, capacity 1, state of charge 0, previous time 0.
module battery_soc_coulomb_counter (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  soc_cc_pkg::reg_idx_t    cfg_index,
	input  soc_cc_pkg::cfg_data_t   cfg_wr_data,
	soc_cc_meas_if.sink             meas,
	soc_cc_result_if.source         result
);
	import soc_cc_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL    = 3'd1;
	localparam logic [2:0] S_DIV18  = 3'd2;
	localparam logic [2:0] S_DIVCAP = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0]     state_q;

	// configuration and running state
	volt_t          full_thr_q;
	volt_t          empty_thr_q;
	divs_t          cap_q;
	soc_t           soc_q;
	time_t          prev_time_q;

	// per-request working values
	logic           neg_q;
	stat_t          res_status_q;

	// output register
	logic           out_valid_q;
	soc_t           out_value_q;
	stat_t          out_status_q;

	logic           accept;
	logic           is_full;
	logic           is_empty;
	time_t          elapsed;
	mul_a_t         cur_u;
	mul_a_t         cur_mag;
	mul_b_t         dt_mag;
	logic           mul_start;
	logic           mul_done;
	prod_t          product;
	logic           div_start;
	logic           div_done;
	divd_t          div_dividend;
	divs_t          div_divisor;
	divd_t          quotient;
	divd_t          used_x100;
	logic signed [SUM_W-1:0] addend;
	logic signed [SUM_W-1:0] soc_sum;
	logic           out_free;

	assign meas.ready = (state_q == S_IDLE);
	assign accept     = meas.valid && meas.ready;

	// full check first: it wins when both thresholds are crossed
	assign is_full  = meas.voltage_mv > full_thr_q;
	assign is_empty = meas.voltage_mv < empty_thr_q;

	// elapsed time wraps at 32 bits and is read as signed
	assign elapsed = meas.timestamp_ms - prev_time_q;
	assign cur_u   = $unsigned(meas.current_ma);
	assign cur_mag = cur_u[MUL_A_W-1] ? (~cur_u + 1'b1) : cur_u;
	assign dt_mag  = elapsed[TIME_W-1] ? (~elapsed + 1'b1) : elapsed;

	assign mul_start = accept && !is_full && !is_empty;

	soc_cc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (cur_mag),
		.b       (dt_mag),
		.done    (mul_done),
		.product (product)
	);

	// |p|*5/18 first, then that quotient *100/capacity, both on magnitudes
	assign used_x100 = (quotient << 6) + (quotient << 5) + (quotient << 2);

	always_comb begin
		div_start    = 1'b0;
		div_dividend = used_x100;
		div_divisor  = cap_q;
		if (state_q == S_MUL) begin
			div_start    = mul_done;
			div_dividend = DIVD_W'({product, 2'b00}) + DIVD_W'(product);
			div_divisor  = DIV_HOUR;
		end else if (state_q == S_DIV18) begin
			div_start    = div_done;
		end
	end

	soc_cc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// sign restored after truncation toward zero; sum held wide then clamped
	assign addend  = neg_q ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
	assign soc_sum = $signed({{(SUM_W-SOC_W){soc_q[SOC_W-1]}}, soc_q}) + addend;

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			full_thr_q  <= '0;
			empty_thr_q <= '0;
			cap_q       <= DIVS_W'(1);
			soc_q       <= '0;
			prev_time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_FULL_THR:  full_thr_q  <= cfg_wr_data[VOLT_W-1:0];
					REG_EMPTY_THR: empty_thr_q <= cfg_wr_data[VOLT_W-1:0];
					// a zero capacity divides as one
					REG_CAPACITY:  cap_q <= (cfg_wr_data[CAP_W-1:0] == '0) ?
						DIVS_W'(1) : cfg_wr_data[CAP_W-1:0];
					REG_INIT_SOC:  soc_q <= $signed(cfg_wr_data[SOC_W-1:0]);
					default: ;
				endcase
			end

			// output register: loads from the sequencer, clears once taken
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_time_q <= meas.timestamp_ms;
						if (is_full) begin
							soc_q   <= SOC_FULL;
							state_q <= S_DONE;
						end else if (is_empty) begin
							soc_q   <= SOC_EMPTY;
							state_q <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					if (mul_done)
						state_q <= S_DIV18;
				end
				S_DIV18: begin
					if (div_done)
						state_q <= S_DIVCAP;
				end
				S_DIVCAP: begin
					if (div_done) begin
						if (soc_sum > $signed(SUM_W'(SOC_MAX)))
							soc_q <= SOC_MAX;
						else if (soc_sum < $signed({{(SUM_W-SOC_W){1'b1}}, SOC_MIN}))
							soc_q <= SOC_MIN;
						else
							soc_q <= soc_sum[SOC_W-1:0];
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload: sign of the product and the status of the result;
	// the running value is the result once the request settles
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= meas.current_ma[CUR_W-1] ^ elapsed[TIME_W-1];
			if (is_full)
				res_status_q <= ST_FULL;
			else if (is_empty)
				res_status_q <= ST_EMPTY;
			else
				res_status_q <= ST_INTEGRATED;
		end else if (state_q == S_DIVCAP && div_done) begin
			if (soc_sum > $signed(SUM_W'(SOC_MAX)) ||
			    soc_sum < $signed({{(SUM_W-SOC_W){1'b1}}, SOC_MIN}))
				res_status_q <= ST_SATURATED;
		end
		if (state_q == S_DONE && out_free) begin
			out_value_q  <= soc_q;
			out_status_q <= res_status_q;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.soc_value  = out_value_q;
	assign result.soc_status = out_status_q;

endmodule

[rtl/core/soc_cc_chk.sv]
// Port-level assertion checker for the state-of-charge block, with its bind.
module soc_cc_chk (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  soc_cc_pkg::soc_t      out_value,
	input  soc_cc_pkg::stat_t     out_status
);
	import soc_cc_pkg::*;

	// one request at a time: the sink closes straight after taking one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a request is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
		else $error("stalled result changed or dropped");

	a_full_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_FULL |-> out_value == SOC_FULL)
		else $error("forced-full result with wrong value");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_EMPTY |-> out_value == SOC_EMPTY)
		else $error("forced-empty result with wrong value");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_SATURATED |-> out_value == SOC_MAX || out_value == SOC_MIN)
		else $error("saturated result not at a limit");

endmodule

bind battery_soc_coulomb_counter soc_cc_chk u_soc_cc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (meas.valid),
	.in_ready   (meas.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_value  (result.soc_value),
	.out_status (result.soc_status)
);
